/* src/ftfps_pkg.sv */
// ----------------------------------------------------------------------------
// Frame timer package
// Shared widths, reset values, opcodes and register indexes for the frame
// timer and its bit-serial arithmetic units.
// ----------------------------------------------------------------------------
`default_nettype none

package ftfps_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned TIME_WIDTH_DEF      = 32;
  localparam int unsigned FPS_WINDOW_MS_DEF   = 1000;
  localparam int unsigned SCALE_FRAC_BITS_DEF = 8;

  // Fixed field widths.
  localparam int unsigned FIELD_W    = 32;  // result fields, frame counts, rate
  localparam int unsigned NOW_W      = 32;  // input time source
  localparam int unsigned SCALE_W    = 16;  // time_scale, Q8.8
  localparam int unsigned STEP_W     = 16;  // step_ms
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 40;  // now_ms and active, padded to bytes
  localparam int unsigned OUT_DATA_W = 8 * FIELD_W;

  // Fraction bits of the Q8.8 scale and of the Q24.8 frame rate.
  localparam int unsigned SCALE_Q_FRAC = 8;

  // Register reset values.
  localparam int unsigned STEP_RESET  = 16;
  localparam int unsigned SCALE_RESET = 256;

  // A frame right after activation in free-running mode counts as 10 ms.
  localparam int unsigned ACT_FRAME_MS = 10;
  localparam int unsigned ACT_W        = SCALE_W + 4;

  // Frame rate numerator: frames * 1000 * 256.
  localparam int unsigned MS_PER_S  = 1000;
  localparam int unsigned FPS_NUM_W = FIELD_W + SCALE_W + SCALE_Q_FRAC;

  typedef enum logic [OP_W-1:0] {
    OP_QUERY  = 2'd0,
    OP_FRAME  = 2'd1,
    OP_ACTIVE = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIXED_STEP = 2'd0,
    CFG_STEP_MS    = 2'd1,
    CFG_TIME_SCALE = 2'd2
  } cfg_idx_e;

endpackage

`default_nettype wire

/* src/frame_timer_with_fps_meter.sv */
// ----------------------------------------------------------------------------
// Frame timer with frames-per-second meter
// Throughput: one request at a time; the next request is accepted once the
//   result of the last one has been loaded into the output register. A frame
//   that updates the rate adds a multiply for the numerator and a divide. The
//   bit-serial multiplier passes (one multiplier bit per cycle) and, on a rate
//   update, the divider set how long a request takes; a result still waiting
//   in the output register holds the next one back until it is taken.
// Reset: asynchronous, active low; all time, frame and rate state clears to
//   zero, step_ms resets to 16 and time_scale to 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_timer_with_fps_meter #(
  parameter int unsigned TIME_WIDTH      = ftfps_pkg::TIME_WIDTH_DEF,
  parameter int unsigned FPS_WINDOW_MS   = ftfps_pkg::FPS_WINDOW_MS_DEF,
  parameter int unsigned SCALE_FRAC_BITS = ftfps_pkg::SCALE_FRAC_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration write channel.
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [ftfps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [ftfps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Request stream.
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // tdata: now_ms[31:0], active[32], zero padding[39:33]
  input  wire logic [ftfps_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: op[1:0]
  input  wire logic [ftfps_pkg::OP_W-1:0]       s_axis_tuser_i,
  // Result stream.
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // tdata: cur_time[31:0], cur_time_unscaled[63:32], frame_count[95:64],
  //   last_frame_time[127:96], last_frame_unscaled[159:128],
  //   frame_start_time[191:160], fps_raw[223:192], fps_scaled[255:224]
  output logic [ftfps_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o
);
  import ftfps_pkg::*;

  localparam int unsigned TW      = TIME_WIDTH;
  localparam int unsigned ACC_W   = TW + SCALE_FRAC_BITS;
  localparam int unsigned MA_W    = (TW > FIELD_W) ? TW : FIELD_W;
  localparam int unsigned MP_W    = MA_W + SCALE_W;
  localparam int unsigned PROD_W  = TW + SCALE_W;
  localparam int unsigned ALIGN_L = (SCALE_FRAC_BITS >= SCALE_Q_FRAC) ?
                                    SCALE_FRAC_BITS - SCALE_Q_FRAC : 0;
  localparam int unsigned ALIGN_R = (SCALE_FRAC_BITS < SCALE_Q_FRAC) ?
                                    SCALE_Q_FRAC - SCALE_FRAC_BITS : 0;
  localparam int unsigned EXT_W   = PROD_W + ALIGN_L;

  typedef enum logic [9:0] {
    S_IDLE      = 10'b00_0000_0001,
    S_DECODE    = 10'b00_0000_0010,
    S_DELTA     = 10'b00_0000_0100,
    S_FRAME     = 10'b00_0000_1000,
    S_NUM_START = 10'b00_0001_0000,
    S_NUM_WAIT  = 10'b00_0010_0000,
    S_DIV_WAIT  = 10'b00_0100_0000,
    S_FPS_START = 10'b00_1000_0000,
    S_FPS_WAIT  = 10'b01_0000_0000,
    S_OUT       = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic              fixed_q, fixed_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SCALE_W-1:0] scale_q, scale_d;

  // Captured request.
  logic [OP_W-1:0]  op_q, op_d;
  logic [NOW_W-1:0] now_q, now_d;
  logic             active_q, active_d;

  // Timer state.
  logic [TW-1:0]      prev_src_q, prev_src_d;
  logic [TW-1:0]      acc_plain_q, acc_plain_d;
  logic [ACC_W-1:0]   acc_scaled_q, acc_scaled_d;
  logic [TW-1:0]      start_scaled_q, start_scaled_d;
  logic [TW-1:0]      start_plain_q, start_plain_d;
  logic [TW-1:0]      len_scaled_q, len_scaled_d;
  logic [TW-1:0]      len_plain_q, len_plain_d;
  logic [FIELD_W-1:0] frames_q, frames_d;
  logic [FIELD_W-1:0] win_frames_q, win_frames_d;
  logic [TW-1:0]      win_start_q, win_start_d;
  logic [FIELD_W-1:0] fps_q, fps_d;
  logic               just_q, just_d;

  // Per-request working values.
  logic [TW-1:0]      delta_q, delta_d;
  logic [TW-1:0]      elapsed_q, elapsed_d;
  logic [FIELD_W-1:0] fps_scaled_q, fps_scaled_d;

  // Result register.
  logic                  m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;

  // Arithmetic units.
  logic                 mul_start, mul_done;
  logic [MA_W-1:0]      mul_a;
  logic [SCALE_W-1:0]   mul_b;
  logic [MP_W-1:0]      mul_prod;
  logic                 div_start, div_done;
  logic [FPS_NUM_W-1:0] div_num, div_quo;

  // Derived values.
  logic              frame_edge;
  logic [TW-1:0]     now_tw, adv_src, adv_delta;
  logic [PROD_W-1:0] delta_prod;
  logic [EXT_W-1:0]  delta_ext;
  logic [ACC_W-1:0]  delta_scaled;
  logic [TW-1:0]     cur_scaled, ws_eff, elapsed, act_len;
  logic [ACT_W-1:0]  act_prod;
  logic              over_window;
  logic [MP_W-1:0]   fs_full;
  logic [FIELD_W-1:0] fs_sat, quo_sat;

  ftfps_smul #(
    .A_W (MA_W),
    .B_W (SCALE_W)
  ) u_smul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  ftfps_sdiv #(
    .NUM_W (FPS_NUM_W),
    .DEN_W (TW)
  ) u_sdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (elapsed_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Time advance: fixed step, activation frame or source clock difference.
  always_comb begin
    frame_edge = (op_q == OP_FRAME);
    now_tw     = TW'(now_q);
    if (fixed_q) begin
      adv_delta = frame_edge ? TW'(step_q) : '0;
      adv_src   = prev_src_q + adv_delta;
    end else begin
      adv_src = now_tw;
      if (just_q) begin
        adv_delta = frame_edge ? TW'(ACT_FRAME_MS) : '0;
      end else begin
        adv_delta = now_tw - prev_src_q;
      end
    end
  end

  // Scaled delta, realigned from Q8.8 to the accumulator's fraction bits.
  always_comb begin
    delta_prod   = PROD_W'(mul_prod);
    delta_ext    = EXT_W'(delta_prod) << ALIGN_L;
    delta_scaled = ACC_W'(delta_ext >> ALIGN_R);
  end

  // Frame bookkeeping and rate window check.
  always_comb begin
    cur_scaled  = acc_scaled_q[ACC_W-1:SCALE_FRAC_BITS];
    act_prod    = ACT_W'(ACT_FRAME_MS) * ACT_W'(scale_q);
    act_len     = TW'(act_prod >> SCALE_Q_FRAC);
    ws_eff      = (win_start_q == '0) ? cur_scaled : win_start_q;
    elapsed     = cur_scaled - ws_eff;
    over_window = (elapsed > TW'(FPS_WINDOW_MS));
  end

  // Saturation of the rate and the scaled rate to 32 bits.
  always_comb begin
    fs_full = mul_prod >> SCALE_Q_FRAC;
    fs_sat  = ((fs_full >> FIELD_W) != '0) ? '1 : FIELD_W'(fs_full);
    quo_sat = ((div_quo >> FIELD_W) != '0) ? '1 : FIELD_W'(div_quo);
    div_num = {mul_prod[FIELD_W+SCALE_W-1:0], {SCALE_Q_FRAC{1'b0}}};
  end

  // Sequencer and next-state logic.
  always_comb begin
    state_d        = state_q;
    fixed_d        = fixed_q;
    step_d         = step_q;
    scale_d        = scale_q;
    op_d           = op_q;
    now_d          = now_q;
    active_d       = active_q;
    prev_src_d     = prev_src_q;
    acc_plain_d    = acc_plain_q;
    acc_scaled_d   = acc_scaled_q;
    start_scaled_d = start_scaled_q;
    start_plain_d  = start_plain_q;
    len_scaled_d   = len_scaled_q;
    len_plain_d    = len_plain_q;
    frames_d       = frames_q;
    win_frames_d   = win_frames_q;
    win_start_d    = win_start_q;
    fps_d          = fps_q;
    just_d         = just_q;
    delta_d        = delta_q;
    elapsed_d      = elapsed_q;
    fps_scaled_d   = fps_scaled_q;
    m_data_d       = m_data_q;
    m_valid_d      = m_valid_q & ~m_axis_tready_i;
    mul_start      = 1'b0;
    mul_a          = '0;
    mul_b          = scale_q;
    div_start      = 1'b0;

    // Register writes; indexes beyond the list are dropped.
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FIXED_STEP: fixed_d = cfg_data_i[0];
        CFG_STEP_MS:    step_d  = STEP_W'(cfg_data_i);
        CFG_TIME_SCALE: scale_d = SCALE_W'(cfg_data_i);
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d     = s_axis_tuser_i;
          now_d    = s_axis_tdata_i[NOW_W-1:0];
          active_d = s_axis_tdata_i[NOW_W];
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (op_q)
          OP_QUERY, OP_FRAME: begin
            prev_src_d = adv_src;
            delta_d    = adv_delta;
            mul_start  = 1'b1;
            mul_a      = MA_W'(adv_delta);
            state_d    = S_DELTA;
          end
          OP_ACTIVE: begin
            just_d  = active_q;
            state_d = S_FPS_START;
          end
          default: state_d = S_FPS_START;
        endcase
      end
      S_DELTA: begin
        if (mul_done) begin
          acc_plain_d  = acc_plain_q + delta_q;
          acc_scaled_d = acc_scaled_q + delta_scaled;
          state_d      = frame_edge ? S_FRAME : S_FPS_START;
        end
      end
      S_FRAME: begin
        if (just_q) begin
          len_scaled_d = act_len;
          len_plain_d  = TW'(ACT_FRAME_MS);
        end else begin
          len_scaled_d = cur_scaled - start_scaled_q;
          len_plain_d  = acc_plain_q - start_plain_q;
        end
        frames_d       = frames_q + FIELD_W'(1);
        win_frames_d   = win_frames_q + FIELD_W'(1);
        just_d         = 1'b0;
        start_scaled_d = cur_scaled;
        start_plain_d  = acc_plain_q;
        elapsed_d      = elapsed;
        if (over_window) begin
          win_start_d = cur_scaled;
          state_d     = S_NUM_START;
        end else begin
          win_start_d = ws_eff;
          state_d     = S_FPS_START;
        end
      end
      S_NUM_START: begin
        // Frames in the window times 1000; the unit latches the count.
        mul_start    = 1'b1;
        mul_a        = MA_W'(win_frames_q);
        mul_b        = SCALE_W'(MS_PER_S);
        win_frames_d = '0;
        state_d      = S_NUM_WAIT;
      end
      S_NUM_WAIT: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_d   = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          fps_d   = quo_sat;
          state_d = S_FPS_START;
        end
      end
      S_FPS_START: begin
        mul_start = 1'b1;
        mul_a     = MA_W'(fps_q);
        state_d   = S_FPS_WAIT;
      end
      S_FPS_WAIT: begin
        if (mul_done) begin
          fps_scaled_d = fs_sat;
          state_d      = S_OUT;
        end
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_data_d  = {fps_scaled_q, fps_q, FIELD_W'(start_scaled_q),
                       FIELD_W'(len_plain_q), FIELD_W'(len_scaled_q), frames_q,
                       FIELD_W'(acc_plain_q), FIELD_W'(cur_scaled)};
          m_valid_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control, configuration and timer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      fixed_q        <= 1'b0;
      step_q         <= STEP_W'(STEP_RESET);
      scale_q        <= SCALE_W'(SCALE_RESET);
      prev_src_q     <= '0;
      acc_plain_q    <= '0;
      acc_scaled_q   <= '0;
      start_scaled_q <= '0;
      start_plain_q  <= '0;
      len_scaled_q   <= '0;
      len_plain_q    <= '0;
      frames_q       <= '0;
      win_frames_q   <= '0;
      win_start_q    <= '0;
      fps_q          <= '0;
      just_q         <= 1'b0;
      m_valid_q      <= 1'b0;
    end else begin
      state_q        <= state_d;
      fixed_q        <= fixed_d;
      step_q         <= step_d;
      scale_q        <= scale_d;
      prev_src_q     <= prev_src_d;
      acc_plain_q    <= acc_plain_d;
      acc_scaled_q   <= acc_scaled_d;
      start_scaled_q <= start_scaled_d;
      start_plain_q  <= start_plain_d;
      len_scaled_q   <= len_scaled_d;
      len_plain_q    <= len_plain_d;
      frames_q       <= frames_d;
      win_frames_q   <= win_frames_d;
      win_start_q    <= win_start_d;
      fps_q          <= fps_d;
      just_q         <= just_d;
      m_valid_q      <= m_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    now_q        <= now_d;
    active_q     <= active_d;
    delta_q      <= delta_d;
    elapsed_q    <= elapsed_d;
    fps_scaled_q <= fps_scaled_d;
    m_data_q     <= m_data_d;
  end

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

`default_nettype wire

/* src/ftfps_smul.sv */
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Shift-and-add multiplier that retires one multiplier bit per cycle. The
// product is held after done until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module ftfps_smul #(
  parameter int unsigned A_W = ftfps_pkg::FIELD_W,
  parameter int unsigned B_W = ftfps_pkg::SCALE_W
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [A_W-1:0]     a_i,
  input  wire logic [B_W-1:0]     b_i,
  output logic                    done_o,
  output logic [A_W+B_W-1:0]      prod_o
);
  import ftfps_pkg::*;

  localparam int unsigned CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

  logic [A_W-1:0]   a_q;
  logic [A_W-1:0]   hi_q, hi_d;
  logic [B_W-1:0]   lo_q, lo_d;
  logic [A_W:0]     sum;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             last;

  // One partial product per cycle, the running sum shifts right into lo.
  always_comb begin
    sum    = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
    last   = (cnt_q == CNT_W'(B_W - 1));
    hi_d   = hi_q;
    lo_d   = lo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      hi_d   = '0;
      lo_d   = b_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      hi_d  = sum[A_W:1];
      lo_d  = {sum[0], lo_q[B_W-1:1]};
      cnt_d = cnt_q + CNT_W'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Sequencing state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and product shift registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
    end
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

`default_nettype wire

/* src/ftfps_sdiv.sv */
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring divider that produces one quotient bit per cycle, most
// significant first. The quotient is held after done until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module ftfps_sdiv #(
  parameter int unsigned NUM_W = ftfps_pkg::FPS_NUM_W,
  parameter int unsigned DEN_W = ftfps_pkg::TIME_WIDTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quo_o
);
  import ftfps_pkg::*;

  localparam int unsigned CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W:0]   trial, diff;
  logic             ge;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  // Bring down one dividend bit, subtract the divisor where it fits.
  always_comb begin
    trial  = {rem_q, quo_q[NUM_W-1]};
    diff   = trial - {1'b0, den_q};
    ge     = (trial >= {1'b0, den_q});
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Sequencing state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Divisor, partial remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
    end
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire
